@@ hw/rtl/recent_history_ring_buffer_macros.svh @@
// Assertion macros used by the top level of the recent history ring buffer.
`ifndef RECENT_HISTORY_RING_BUFFER_MACROS_SVH
`define RECENT_HISTORY_RING_BUFFER_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define RHRB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define RHRB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/rhrb_pkg.sv @@
// Types and constants of the recent history ring buffer.
`timescale 1ns / 1ps

package rhrb_pkg;

  localparam int unsigned DEPTH_DEFAULT = 16;

  localparam logic REQ_RECORD = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic signed [31:0] order_value;
    logic signed [15:0] count_requested;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] entry_value;
    logic               status;
    logic               last_of_run;
  } out_req_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic record;
    logic start;
    logic load_empty;
    logic advance;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic fill_zero;
    logic count_pos;
    logic last;
  } sts_t;

endpackage

@@ hw/rtl/rhrb_datapath.sv @@
// Datapath of the recent history ring buffer: entry memory, pointers and counters.
`timescale 1ns / 1ps

module rhrb_datapath #(
  parameter int unsigned DEPTH = rhrb_pkg::DEPTH_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rhrb_pkg::in_req_t in_req_i,
  input  rhrb_pkg::cmd_t    cmd_i,
  output rhrb_pkg::sts_t    sts_o,
  output rhrb_pkg::out_req_t out_req_o
);

  localparam int unsigned PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(DEPTH + 1);
  localparam int unsigned CNT_W  = 15;
  localparam int unsigned MW     = (FILL_W > CNT_W) ? FILL_W : CNT_W;

  logic [31:0]       mem_q [DEPTH];
  logic [31:0]       rdata_q;
  logic [PTR_W-1:0]  wp_q, wp_d, rp_q, rp_d;
  logic [FILL_W-1:0] fill_q, fill_d, remaining_q, remaining_d;
  logic              empty_q, empty_d;
  logic [PTR_W-1:0]  wp_prev, rp_prev, rd_addr;
  logic [MW-1:0]     count_ext, fill_ext, n_sel;
  logic [FILL_W-1:0] n;

  assign wp_prev = (wp_q == '0) ? PTR_W'(DEPTH - 1) : wp_q - PTR_W'(1);
  assign rp_prev = (rp_q == '0) ? PTR_W'(DEPTH - 1) : rp_q - PTR_W'(1);
  assign rd_addr = cmd_i.start ? wp_prev : rp_prev;

  // A positive count is below 2^15, so its low bits carry the whole value.
  assign count_ext = MW'(in_req_i.count_requested[CNT_W-1:0]);
  assign fill_ext  = MW'(fill_q);
  assign n_sel     = (count_ext < fill_ext) ? count_ext : fill_ext;
  assign n         = n_sel[FILL_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.record) begin
      mem_q[wp_q] <= in_req_i.order_value;
    end
    if (cmd_i.start || cmd_i.advance) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_comb begin
    wp_d        = wp_q;
    fill_d      = fill_q;
    rp_d        = rp_q;
    remaining_d = remaining_q;
    empty_d     = empty_q;
    if (cmd_i.record) begin
      wp_d = (wp_q == PTR_W'(DEPTH - 1)) ? '0 : wp_q + PTR_W'(1);
      if (fill_q != FILL_W'(DEPTH)) begin
        fill_d = fill_q + FILL_W'(1);
      end
    end
    if (cmd_i.start) begin
      rp_d        = wp_prev;
      remaining_d = n;
      empty_d     = 1'b0;
    end
    if (cmd_i.load_empty) begin
      remaining_d = FILL_W'(1);
      empty_d     = 1'b1;
    end
    if (cmd_i.advance) begin
      rp_d        = rp_prev;
      remaining_d = remaining_q - FILL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q        <= '0;
      fill_q      <= '0;
      rp_q        <= '0;
      remaining_q <= '0;
      empty_q     <= 1'b0;
    end else begin
      wp_q        <= wp_d;
      fill_q      <= fill_d;
      rp_q        <= rp_d;
      remaining_q <= remaining_d;
      empty_q     <= empty_d;
    end
  end

  assign sts_o.fill_zero = (fill_q == '0);
  assign sts_o.count_pos = !in_req_i.count_requested[15] && (in_req_i.count_requested != '0);
  assign sts_o.last      = (remaining_q == FILL_W'(1));

  assign out_req_o.entry_value = empty_q ? '0 : signed'(rdata_q);
  assign out_req_o.status      = empty_q;
  assign out_req_o.last_of_run = (remaining_q == FILL_W'(1));

endmodule

@@ hw/rtl/rhrb_controller.sv @@
// Controller of the recent history ring buffer: request sequencing and handshakes.
`timescale 1ns / 1ps

module rhrb_controller (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           req_type_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  input  rhrb_pkg::sts_t sts_i,
  output rhrb_pkg::cmd_t cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_BUSY = 1'b1;

  logic state_q, state_d;
  logic in_acc, out_acc;

  assign in_stall_o  = (state_q == ST_BUSY);
  assign out_valid_o = (state_q == ST_BUSY);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_acc     = out_valid_o && !out_stall_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (req_type_i == rhrb_pkg::REQ_RECORD) begin
            cmd_o.record = 1'b1;
          end else if (sts_i.fill_zero) begin
            cmd_o.load_empty = 1'b1;
            state_d          = ST_BUSY;
          end else if (sts_i.count_pos) begin
            cmd_o.start = 1'b1;
            state_d     = ST_BUSY;
          end
        end
      end
      ST_BUSY: begin
        if (out_acc) begin
          if (sts_i.last) begin
            state_d = ST_IDLE;
          end else begin
            // The next older entry is read as the current one is taken.
            cmd_o.advance = 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ hw/rtl/recent_history_ring_buffer.sv @@
// A record is stored as it is accepted; a query's first result comes in the cycle after it.
// Records go in one per cycle while idle; a query gives min(count, fill) results, one per
// cycle while the receiver does not stall, or one empty result on an empty log; the input is
// stalled until the last is taken. The entry memory's single registered read port sets this rate.
// Reset clears the pointers and fill count; the entry memory is not cleared.
`timescale 1ns / 1ps

`include "recent_history_ring_buffer_macros.svh"

module recent_history_ring_buffer #(
  parameter int unsigned DEPTH = rhrb_pkg::DEPTH_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  rhrb_pkg::in_req_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rhrb_pkg::out_req_t out_req_o
);

  rhrb_pkg::cmd_t cmd;
  rhrb_pkg::sts_t sts;

  rhrb_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .req_type_i  (in_req_i.req_type),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rhrb_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_req_i  (in_req_i),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .out_req_o (out_req_o)
  );

  `RHRB_ASSERT_NOW(a_busy_stalls_input, out_valid_o, in_stall_o, "input accepted during a query")
  `RHRB_ASSERT_NOW(a_empty_is_last, out_valid_o && out_req_o.status, out_req_o.last_of_run, "empty status not last")
  `RHRB_ASSERT_NEXT(a_run_continues, out_valid_o && !out_stall_i && !out_req_o.last_of_run, out_valid_o, "query run cut short")
  `RHRB_ASSERT_NEXT(a_no_result_on_bad_count, in_valid_i && !in_stall_o && (in_req_i.req_type == rhrb_pkg::REQ_QUERY) && !sts.fill_zero && !sts.count_pos, !out_valid_o, "result for nonpositive count")

endmodule

@@ sim/recent_history_ring_buffer_tb.sv @@
// Self-checking testbench for the recent history ring buffer with random idling on both sides.
`timescale 1ns / 1ps

module recent_history_ring_buffer_tb;

  localparam int unsigned HIST_DEPTH = rhrb_pkg::DEPTH_DEFAULT;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  rhrb_pkg::in_req_t  in_req_i;
  logic               out_valid_o;
  logic               out_stall_i;
  rhrb_pkg::out_req_t out_req_o;

  recent_history_ring_buffer #(
    .DEPTH(HIST_DEPTH)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_req_o  (out_req_o)
  );

  // Predicted history: ring contents, write slot and number of valid entries.
  logic signed [31:0] history_mem [HIST_DEPTH];
  int unsigned        hist_wptr;
  int unsigned        hist_fill;
  rhrb_pkg::out_req_t pending_entries [$];
  rhrb_pkg::out_req_t oldest_entry;

  int unsigned error_count;
  int unsigned shown_count;
  int unsigned results_seen;
  int unsigned records_sent;
  int unsigned queries_sent;
  int unsigned empty_replies;
  int unsigned free_run_left;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Mostly short gaps, a few long ones.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  task automatic predict_history(input rhrb_pkg::in_req_t req);
    int unsigned        n;
    int unsigned        pos;
    rhrb_pkg::out_req_t res;
    if (req.req_type == rhrb_pkg::REQ_RECORD) begin
      records_sent++;
      history_mem[hist_wptr] = req.order_value;
      hist_wptr = (hist_wptr + 1) % HIST_DEPTH;
      if (hist_fill < HIST_DEPTH) hist_fill++;
    end else begin
      queries_sent++;
      if (hist_fill == 0) begin
        // An empty log answers every query once, even a zero or negative count.
        empty_replies++;
        res.entry_value = '0;
        res.status      = 1'b1;
        res.last_of_run = 1'b1;
        pending_entries.push_back(res);
      end else if (!req.count_requested[15] && req.count_requested != 16'sd0) begin
        n = {16'd0, req.count_requested};
        if (n > hist_fill) n = hist_fill;
        pos = (hist_wptr + HIST_DEPTH - 1) % HIST_DEPTH;
        for (int unsigned k = 0; k < n; k++) begin
          res.entry_value = history_mem[pos];
          res.status      = 1'b0;
          res.last_of_run = (k + 1 == n);
          pending_entries.push_back(res);
          pos = (pos + HIST_DEPTH - 1) % HIST_DEPTH;
        end
      end
    end
  endtask

  // Called right after a rising edge; returns right after the edge that accepts the request.
  task automatic send_request(input logic kind, input logic signed [31:0] value,
                              input logic signed [15:0] count);
    rhrb_pkg::in_req_t req;
    int unsigned       gap;
    req.req_type        = kind;
    req.order_value     = value;
    req.count_requested = count;
    if (free_run_left > 0) begin
      free_run_left--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 15) == 0) free_run_left = $urandom_range(8, 30);
      gap = pick_gap();
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do @(posedge clk_i); while (in_stall_o);
    predict_history(req);
  endtask

  task automatic record_value(input logic signed [31:0] value);
    send_request(rhrb_pkg::REQ_RECORD, value, 16'($urandom));
  endtask

  task automatic query_recent(input logic signed [15:0] count);
    send_request(rhrb_pkg::REQ_QUERY, 32'($urandom), count);
  endtask

  task automatic test_empty_log();
    query_recent(16'sd0);
    query_recent(16'sh8000);
    query_recent(16'sh7fff);
    query_recent(16'sd1);
  endtask

  task automatic test_extreme_values();
    record_value(32'sh8000_0000);
    record_value(32'sh7fff_ffff);
    record_value(32'sd0);
    record_value(-32'sd1);
    record_value(32'sh5555_aaaa);
    query_recent(16'sd1);
    query_recent(16'sd3);
    query_recent(16'sd5);
    query_recent(16'sd6);
    query_recent(16'sd0);
    query_recent(-16'sd1);
    query_recent(16'sh8000);
    query_recent(16'sh7fff);
  endtask

  // Fill past the ring size so the oldest entries are overwritten.
  task automatic test_wraparound();
    repeat (21) record_value(32'($urandom));
    query_recent(16'(HIST_DEPTH));
    query_recent(16'(HIST_DEPTH + 1));
    query_recent(16'sh7fff);
    query_recent(16'(HIST_DEPTH - 1));
  endtask

  task automatic test_random_mix(input int unsigned num_items);
    int unsigned r;
    int          cnt;
    for (int unsigned i = 0; i < num_items; i++) begin
      if ($urandom_range(0, 99) < 55) begin
        r = $urandom_range(0, 9);
        if (r == 0) record_value(32'sh8000_0000);
        else if (r == 1) record_value(32'sh7fff_ffff);
        else record_value(32'($urandom));
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          cnt = $urandom_range(1, 20);
        end else if (r < 65) begin
          cnt = int'(hist_fill) + int'($urandom_range(0, 2)) - 1;
        end else if (r < 80) begin
          cnt = ($urandom_range(0, 1) == 0) ? 0 : -int'($urandom_range(1, 32768));
        end else begin
          cnt = int'($urandom_range(0, 65535));
        end
        query_recent(16'(cnt));
      end
    end
  endtask

  // Receiver stalls: runs of stall and of no stall, some of them long.
  initial begin
    int unsigned run_left;
    out_stall_i = 1'b0;
    run_left    = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (run_left > 0) begin
        run_left--;
      end else if (!out_stall_i && $urandom_range(0, 99) < 35) begin
        out_stall_i <= 1'b1;
        run_left = pick_gap();
      end else begin
        out_stall_i <= 1'b0;
        run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
                                                : $urandom_range(0, 12);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (pending_entries.size() == 0) begin
        error_count++;
        if (shown_count < 10) begin
          shown_count++;
          $display("%0t: unexpected result value=%0d status=%0b last=%0b", $realtime,
                   out_req_o.entry_value, out_req_o.status, out_req_o.last_of_run);
        end
      end else begin
        oldest_entry = pending_entries.pop_front();
        if (out_req_o.entry_value !== oldest_entry.entry_value ||
            out_req_o.status !== oldest_entry.status ||
            out_req_o.last_of_run !== oldest_entry.last_of_run) begin
          error_count++;
          if (shown_count < 10) begin
            shown_count++;
            $display({"%0t: mismatch value exp %0d got %0d, ",
                      "status exp %0b got %0b, last exp %0b got %0b"},
                     $realtime, oldest_entry.entry_value, out_req_o.entry_value,
                     oldest_entry.status, out_req_o.status,
                     oldest_entry.last_of_run, out_req_o.last_of_run);
          end
        end
      end
    end
  end

  initial begin
    #(10_000_000);
    $display("Timed out with %0d results still outstanding.", pending_entries.size());
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int unsigned waited;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_req_i      = '0;
    hist_wptr     = 0;
    hist_fill     = 0;
    error_count   = 0;
    shown_count   = 0;
    results_seen  = 0;
    records_sent  = 0;
    queries_sent  = 0;
    empty_replies = 0;
    free_run_left = 0;
    waited        = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_log();
    test_extreme_values();
    test_wraparound();
    test_random_mix(290);

    in_valid_i <= 1'b0;
    while (pending_entries.size() != 0 && waited < 200000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (20) @(posedge clk_i);
    if (pending_entries.size() != 0) begin
      error_count += pending_entries.size();
      $display("%0d expected results never arrived.", pending_entries.size());
    end

    $display("Sent %0d records and %0d queries (%0d on an empty log).", records_sent,
             queries_sent, empty_replies);
    $display("Checked %0d results, %0d failures.", results_seen, error_count);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
